FILE: rtl/core/lhm_pkg.sv
package lhm_pkg;

    // Counter width; counters wrap modulo 2**COUNT_BITS
    localparam int COUNT_BITS   = 64;
    localparam int NUM_LIMITS   = 6;
    localparam int NUM_COUNTERS = 8;
    localparam int NS_PER_US    = 1000;

    localparam int LIMIT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TIME_W     = 64;
    // Threshold in ns: limit * 1000 + 999 needs 42 bits
    localparam int THR_W      = 42;

    localparam logic [2:0] TOTAL_INDEX     = 3'd7;
    localparam logic [2:0] OVERFLOW_BUCKET = 3'd6;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_END   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    typedef logic [LIMIT_W-1:0] limit_array_t [NUM_LIMITS];
    localparam limit_array_t LIMIT_RESET = '{32'd1, 32'd5, 32'd10, 32'd50, 32'd100, 32'd500};

    typedef logic [NUM_LIMITS-1:0][THR_W-1:0] thr_array_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [TIME_W-1:0] time_ns;
        logic [2:0]        read_index;
    } lhm_in_t;

    typedef struct packed {
        logic [63:0] count_value;
        logic        recorded;
        logic [2:0]  hit_bucket;
    } lhm_out_t;

    // dt_us <= limit  <=>  dt_ns <= limit * 1000 + 999
    function automatic logic [THR_W-1:0] lim_to_thr(input logic [LIMIT_W-1:0] lim);
        return THR_W'(lim) * THR_W'(NS_PER_US) + THR_W'(NS_PER_US - 1);
    endfunction

endpackage

FILE: rtl/core/lhm_cfg.sv
module lhm_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lhm_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [lhm_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output lhm_pkg::thr_array_t               thr
);
    import lhm_pkg::*;

    thr_array_t          thr_reg;
    thr_array_t          thr_next;
    logic [THR_W-1:0]    wr_thr;

    // Convert the written limit to a ns threshold once, at write time
    assign wr_thr = lim_to_thr(cfg_wr_data[LIMIT_W-1:0]);

    always_comb begin
        thr_next = thr_reg;
        for (int i = 0; i < NUM_LIMITS; i++) begin
            if (cfg_wr_en && (cfg_wr_index == CFG_IDX_W'(i))) begin
                thr_next[i] = wr_thr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LIMITS; i++) begin
                thr_reg[i] <= lim_to_thr(LIMIT_RESET[i]);
            end
        end else begin
            thr_reg <= thr_next;
        end
    end

    assign thr = thr_reg;

endmodule

FILE: rtl/core/lhm_core.sv
module lhm_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  lhm_pkg::lhm_in_t     item,
    input  lhm_pkg::thr_array_t  thr,
    output lhm_pkg::lhm_out_t    result
);
    import lhm_pkg::*;

    logic [TIME_W-1:0]       pending_reg;
    logic [TIME_W-1:0]       pending_next;
    count_t                  cnt_reg [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] inc_en;
    logic [TIME_W-1:0]       diff_ns;
    logic [NUM_LIMITS-1:0]   fit;
    logic [2:0]              bucket;
    logic                    count_it;

    // Wrapping elapsed time, then parallel threshold compares
    assign diff_ns = item.time_ns - pending_reg;

    always_comb begin
        for (int i = 0; i < NUM_LIMITS; i++) begin
            fit[i] = (diff_ns <= TIME_W'(thr[i]));
        end
    end

    // First fitting bucket wins; none fits means overflow
    always_comb begin
        bucket = OVERFLOW_BUCKET;
        for (int i = NUM_LIMITS - 1; i >= 0; i--) begin
            if (fit[i]) begin
                bucket = 3'(i);
            end
        end
    end

    always_comb begin
        pending_next       = pending_reg;
        count_it           = 1'b0;
        result.count_value = '0;
        case (req_type_t'(item.req_type))
            REQ_START: begin
                pending_next = item.time_ns;
            end
            REQ_END: begin
                count_it     = (pending_reg != '0);
                pending_next = '0;
            end
            REQ_READ: begin
                result.count_value = 64'(cnt_reg[item.read_index]);
            end
            default: begin
            end
        endcase
        result.recorded   = count_it;
        result.hit_bucket = count_it ? bucket : 3'd0;
    end

    always_comb begin
        for (int i = 0; i < NUM_COUNTERS; i++) begin
            inc_en[i] = step && count_it &&
                        ((3'(i) == TOTAL_INDEX) || (3'(i) == bucket));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            if (step) begin
                pending_reg <= pending_next;
            end
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                if (inc_en[i]) begin
                    cnt_reg[i] <= cnt_reg[i] + 1'b1;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_end_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (item.req_type == REQ_END) |=> pending_reg == '0)
        else $error("pending start not cleared after end event");

    a_idle_holds_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(pending_reg))
        else $error("pending start changed without a step");

    a_total_tracks_record: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.recorded |=>
            cnt_reg[TOTAL_INDEX] == COUNT_BITS'($past(cnt_reg[TOTAL_INDEX]) + 1'b1))
        else $error("total counter missed a recorded end event");

    a_total_idle_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !(step && result.recorded) |=> $stable(cnt_reg[TOTAL_INDEX]))
        else $error("total counter moved without a recorded end event");

    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        result.hit_bucket != TOTAL_INDEX)
        else $error("hit bucket points at the total counter");
`endif

endmodule

FILE: rtl/core/latency_histogram_monitor.sv
// Latency histogram monitor. Send a start event (req_type 0) with a ns timestamp,
// then an end event (req_type 1); the end event counts the elapsed time, in
// whole microseconds, into the first of buckets 0..5 whose limit it does not
// exceed (overflow goes to bucket 6) and bumps the total counter 7, provided a
// non-zero start was pending. A read event (req_type 2) returns counter
// read_index. Every input transfer yields exactly one output transfer. The
// block takes one transfer per cycle while the receiver keeps up; a result
// passes through the input register, then the result register, before it
// is presented. The rate is set by the 64-bit elapsed-time subtract and
// compare in the core; bucket limits are converted to ns thresholds when written,
// so no divide sits in the item path. Write limits only while the block is idle.
// Counters reset to zero and wrap.
module latency_histogram_monitor (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  lhm_pkg::lhm_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output lhm_pkg::lhm_out_t               m_data,
    input  logic                            cfg_wr_en,
    input  logic [lhm_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [lhm_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import lhm_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    lhm_in_t    in_item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    lhm_out_t   out_data_reg;
    lhm_out_t   core_result;
    thr_array_t thr;
    logic       out_free;
    logic       step;
    logic       s_fire;

    // Advance the held item whenever the result register is empty or draining
    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_data;
        end
        if (step) begin
            out_data_reg <= core_result;
        end
    end

    lhm_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .thr          (thr)
    );

    lhm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .thr     (thr),
        .result  (core_result)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: tb/tb_latency_histogram_monitor.sv
`timescale 1ns / 100ps

module tb_latency_histogram_monitor;
    import lhm_pkg::*;

    // Generous ceiling: ~2000 transfers, each possibly waiting out a sender gap,
    // a sluggish receiver and the long receiver hold-off.
    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_OFF_CYCLES = 120;
    // Two-stage pipeline; the settle wait covers it before a register write.
    localparam int SETTLE_CYCLES   = 6;

    // Register map of the write port; the top two indexes hold no register.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIMIT0, REG_LIMIT1, REG_LIMIT2, REG_LIMIT3, REG_LIMIT4, REG_LIMIT5,
        REG_SPARE6, REG_SPARE7
    } cfg_reg_t;

    // Receiver behavior, re-picked at random whenever its mode count runs out.
    typedef enum int {RX_STEADY, RX_BUSY, RX_SLUGGISH} rx_mode_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    lhm_in_t               s_data       = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    lhm_out_t              m_data;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;

    // Shadow copy of the histogram state, advanced on every accepted transfer.
    logic [TIME_W-1:0] shadow_start_ns;
    count_t            shadow_counts [NUM_COUNTERS];
    limit_array_t      shadow_limits;
    // Outcomes still owed by the block, oldest first.
    lhm_out_t          due_outcomes [$];

    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned burst_left    = 0;
    bit          steady_sender = 1'b0;
    bit          hold_off_req  = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned mode_left     = 0;
    rx_mode_t    rx_mode       = RX_STEADY;

    latency_histogram_monitor DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow histogram
    // ------------------------------------------------------------------

    task automatic flag_error(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic clear_shadow();
        shadow_start_ns = '0;
        shadow_limits   = LIMIT_RESET;
        for (int i = 0; i < NUM_COUNTERS; i++) begin
            shadow_counts[i] = '0;
        end
    endtask

    // Advance the shadow state by one accepted event and queue its outcome.
    task automatic account_event(input lhm_in_t ev);
        lhm_out_t          outcome;
        logic [TIME_W-1:0] elapsed_us;
        logic [2:0]        bucket;
        outcome = '0;
        case (req_type_t'(ev.req_type))
            REQ_START: begin
                shadow_start_ns = ev.time_ns;
            end
            REQ_END: begin
                // A zero start means nothing is pending: count nothing.
                if (shadow_start_ns != '0) begin
                    // Wrapping difference, so time going backwards lands far out.
                    elapsed_us = (ev.time_ns - shadow_start_ns) / TIME_W'(NS_PER_US);
                    bucket = OVERFLOW_BUCKET;
                    // Scan from the top so the lowest matching bucket wins,
                    // even when the limits are out of order.
                    for (int i = NUM_LIMITS - 1; i >= 0; i--) begin
                        if (elapsed_us <= TIME_W'(shadow_limits[i])) bucket = 3'(i);
                    end
                    shadow_counts[TOTAL_INDEX] = shadow_counts[TOTAL_INDEX] + 1;
                    shadow_counts[bucket]      = shadow_counts[bucket] + 1;
                    outcome.recorded   = 1'b1;
                    outcome.hit_bucket = bucket;
                end
                shadow_start_ns = '0;
            end
            REQ_READ: begin
                outcome.count_value = 64'(shadow_counts[ev.read_index]);
            end
            default: ;  // unknown request: no state change, all-zero outcome
        endcase
        due_outcomes.push_back(outcome);
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    function automatic lhm_in_t make_event(input req_type_t kind,
                                           input logic [TIME_W-1:0] t,
                                           input logic [2:0] idx);
        lhm_in_t ev;
        ev.req_type   = kind;
        ev.time_ns    = t;
        ev.read_index = idx;
        return ev;
    endfunction

    // Offer one event and hold it until the transfer happens. The sender works in
    // bursts: between bursts, drop valid for a random gap (sometimes none).
    task automatic send_event(input lhm_in_t ev);
        int unsigned gap;
        if (burst_left == 0 && !steady_sender) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left != 0) burst_left--;
        s_valid <= 1'b1;
        s_data  <= ev;
        // Sample ready as it stood before the edge; valid was high there.
        do @(posedge aclk); while (s_ready !== 1'b1);
        account_event(ev);
    endtask

    // Unused fields carry random bits so every input bit toggles.
    task automatic start_at(input logic [TIME_W-1:0] t);
        send_event(make_event(REQ_START, t, 3'($urandom)));
    endtask

    task automatic end_at(input logic [TIME_W-1:0] t);
        send_event(make_event(REQ_END, t, 3'($urandom)));
    endtask

    task automatic read_counter(input logic [2:0] idx);
        send_event(make_event(REQ_READ, {$urandom, $urandom}, idx));
    endtask

    // Drop valid and hold off until every owed outcome has arrived, then let the
    // pipeline settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (due_outcomes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all six limits back to back on an idle block, then poke the two
    // spare indexes, which must leave the limits untouched.
    task automatic apply_limits(input limit_array_t lims);
        wait_idle();
        for (int i = 0; i < NUM_LIMITS; i++) begin
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= CFG_IDX_W'(REG_LIMIT0 + i);
            cfg_wr_data  <= lims[i];
            @(posedge aclk);
            shadow_limits[i] = lims[i];
        end
        cfg_wr_index <= REG_SPARE6;
        cfg_wr_data  <= $urandom;
        @(posedge aclk);
        cfg_wr_index <= REG_SPARE7;
        cfg_wr_data  <= $urandom;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Elapsed time aimed at the current limits: inside, just over, just under
    // a bucket edge, small, or anything at all.
    function automatic logic [TIME_W-1:0] pick_elapsed_ns();
        logic [TIME_W-1:0] edge_ns;
        edge_ns = TIME_W'(shadow_limits[$urandom_range(0, NUM_LIMITS - 1)])
                  * TIME_W'(NS_PER_US);
        case ($urandom_range(0, 4))
            0:       return edge_ns + $urandom_range(0, NS_PER_US - 1);
            1:       return edge_ns + NS_PER_US + $urandom_range(0, NS_PER_US - 1);
            2:       return TIME_W'($urandom_range(0, 600000));
            3:       return {$urandom, $urandom};
            default: return edge_ns - $urandom_range(0, 3 * NS_PER_US);
        endcase
    endfunction

    // Mostly well-formed start/end pairs; the rest reads and noise.
    task automatic random_traffic(input int unsigned n);
        int unsigned       sent;
        int unsigned       pick;
        logic [TIME_W-1:0] t0;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            t0   = {$urandom, $urandom};
            if (pick < 60) begin
                start_at(t0);
                end_at(t0 + pick_elapsed_ns());
                sent += 2;
            end else if (pick < 80) begin
                read_counter(3'($urandom));
                sent++;
            end else if (pick < 87) begin
                end_at(t0);                 // often nothing pending
                sent++;
            end else if (pick < 92) begin
                start_at(t0);               // lone start, overwritten later
                sent++;
            end else if (pick < 96) begin
                send_event(make_event(REQ_NONE, t0, 3'($urandom)));
                sent++;
            end else begin
                start_at('0);               // zero start reads as nothing pending
                end_at(t0);
                sent += 2;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_cases();
        read_counter(TOTAL_INDEX);                        // clear after reset
        send_event(make_event(REQ_NONE, '1, '1));         // unknown request
        end_at('1);                                       // end with nothing pending
        start_at('0);            end_at(64'd5000);        // zero start not pending
        start_at(64'd1);         end_at(64'd2000);        // 1 us, bucket 0 inclusive
        start_at(64'd3);         end_at(64'd10002);       // 9 us, bucket 2
        start_at(64'd7);         end_at(64'd500006);      // 499 us, bucket 5
        start_at(64'd7);         end_at(64'd501007);      // 501 us, overflow
        start_at(64'd2000000);   end_at(64'd1000);        // backwards, wraps
        start_at('1);            end_at(64'd5);           // wraps across the top
        start_at(64'd9);         start_at(64'd50009);     // second start wins
        end_at(64'd60009);
        for (int i = 0; i < NUM_COUNTERS; i++) begin
            read_counter(3'(i));
        end
    endtask

    task automatic test_default_limits();
        random_traffic(400);
    endtask

    task automatic test_limit_extremes();
        limit_array_t lims;
        lims = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        apply_limits(lims);
        start_at(64'd1); end_at(64'd1000);                // 0 us fits bucket 0
        start_at(64'd1); end_at(64'd1001);                // 1 us overflows
        random_traffic(200);

        lims = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        apply_limits(lims);
        start_at(64'd1); end_at(64'd4294967296000);       // exactly the top limit
        start_at(64'd1); end_at(64'd4294967297000);       // one past it
        random_traffic(200);

        // Out of order: first match in index order still decides.
        lims = '{32'd100, 32'd5, 32'd1000, 32'd1, 32'd0, 32'd50};
        apply_limits(lims);
        random_traffic(200);
    endtask

    task automatic test_random_limits();
        limit_array_t lims;
        repeat (3) begin
            for (int i = 0; i < NUM_LIMITS; i++) begin
                lims[i] = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 1000);
            end
            apply_limits(lims);
            random_traffic(250);
        end
    endtask

    // Stall the receiver long enough for the block to fill and stall its input
    // while the sender keeps offering; later pause the sender until drained.
    task automatic test_flow_control();
        apply_limits(LIMIT_RESET);
        steady_sender = 1'b1;
        hold_off_req  = 1'b1;
        random_traffic(60);
        steady_sender = 1'b0;
        random_traffic(100);
        wait_idle();
        random_traffic(100);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    // Receiver ready pattern, with a long hold-off counted here on request.
    always @(posedge aclk) begin
        if (hold_off_req) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
        end
        if (mode_left == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(8, 64);
        end else begin
            mode_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STEADY: m_ready <= 1'b1;
                RX_BUSY:   m_ready <= ($urandom_range(0, 3) != 0);
                default:   m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compare each result transfer with the oldest owed outcome.
    always @(posedge aclk) begin : check_outcomes
        lhm_out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (due_outcomes.size() == 0) begin
                flag_error($sformatf("unexpected result count=%0h rec=%0b bucket=%0d",
                                     m_data.count_value, m_data.recorded,
                                     m_data.hit_bucket));
            end else begin
                want = due_outcomes.pop_front();
                if (m_data.count_value !== want.count_value)
                    flag_error($sformatf("count_value got %0h want %0h",
                                         m_data.count_value, want.count_value));
                if (m_data.recorded !== want.recorded)
                    flag_error($sformatf("recorded got %0b want %0b",
                                         m_data.recorded, want.recorded));
                if (m_data.hit_bucket !== want.hit_bucket)
                    flag_error($sformatf("hit_bucket got %0d want %0d",
                                         m_data.hit_bucket, want.hit_bucket));
            end
        end
    end

    // Watchdog: end the run if it stalls.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL latency_histogram_monitor");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        clear_shadow();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_default_limits();
        test_limit_extremes();
        test_random_limits();
        test_flow_control();

        // Drain, then let any stray result show up before judging.
        wait_idle();
        if (error_count == 0) begin
            $display("PASS latency_histogram_monitor");
        end else begin
            $display("FAIL latency_histogram_monitor");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/lhm_pkg.sv
rtl/core/lhm_cfg.sv
rtl/core/lhm_core.sv
rtl/core/latency_histogram_monitor.sv
tb/tb_latency_histogram_monitor.sv
